FILE: rtl/core/fully_assoc_lru_cache_lookup_assert.svh
// assertion macros for the lru cache lookup block
`ifndef FULLY_ASSOC_LRU_CACHE_LOOKUP_ASSERT_SVH
`define FULLY_ASSOC_LRU_CACHE_LOOKUP_ASSERT_SVH

// same-cycle implication, held off during reset
`define FALRU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define FALRU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/falru_pkg.sv
`default_nettype none

package falru_pkg;

    localparam int LINES_DEFAULT = 16;
    localparam int ADDR_W        = 32;
    localparam int TAG_SHIFT     = 2;
    localparam int TAG_W         = ADDR_W - TAG_SHIFT;
    localparam int CNT_W         = 32;

    // controller to datapath
    typedef struct packed {
        logic req_ready;
        logic load_req;
        logic latch_cmp;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/core/falru_if.sv
`default_nettype none

interface falru_req_if;
    logic                        valid;
    logic                        ready;
    logic [falru_pkg::ADDR_W-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface falru_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [falru_pkg::CNT_W-1:0] hits_so_far;
    logic [falru_pkg::CNT_W-1:0] accesses_so_far;

    modport source (output valid, output hit, output hits_so_far,
                    output accesses_so_far, input ready);
    modport sink   (input valid, input hit, input hits_so_far,
                    input accesses_so_far, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/falru_datapath.sv
`default_nettype none

module falru_datapath #(
    parameter int LINES = falru_pkg::LINES_DEFAULT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire falru_pkg::t_dp_cmd           i_cmd,
    input  wire logic [falru_pkg::ADDR_W-1:0] i_address,
    input  wire logic                         i_rsp_ready,
    output falru_pkg::t_dp_sts                o_sts,
    output logic                              o_rsp_valid,
    output logic                              o_hit,
    output logic [falru_pkg::CNT_W-1:0]       o_hits_so_far,
    output logic [falru_pkg::CNT_W-1:0]       o_accesses_so_far
);

    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam logic [IDX_W-1:0] RANK_OLDEST = IDX_W'(LINES - 1);

    logic [falru_pkg::TAG_W-1:0] r_req_tag;
    logic [falru_pkg::TAG_W-1:0] r_tag [LINES];
    logic [LINES-1:0]            r_valid;
    logic [IDX_W-1:0]            r_rank [LINES];
    logic                        r_hit;
    logic [IDX_W-1:0]            r_line;
    logic [falru_pkg::CNT_W-1:0] r_hit_total;
    logic [falru_pkg::CNT_W-1:0] r_acc_total;
    logic                        r_out_valid;
    logic                        r_out_hit;
    logic [falru_pkg::CNT_W-1:0] r_out_hits;
    logic [falru_pkg::CNT_W-1:0] r_out_acc;

    logic                        found;
    logic [IDX_W-1:0]            match_line;
    logic                        have_empty;
    logic [IDX_W-1:0]            empty_line;
    logic [IDX_W-1:0]            victim_line;
    logic [IDX_W-1:0]            n_line;
    logic [IDX_W-1:0]            old_rank;
    logic [falru_pkg::CNT_W-1:0] n_hit_total;
    logic [falru_pkg::CNT_W-1:0] n_acc_total;

    // tag compare, first empty line and lru victim, lowest index wins
    always_comb begin
        found       = 1'b0;
        match_line  = '0;
        have_empty  = 1'b0;
        empty_line  = '0;
        victim_line = '0;
        for (int i = LINES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tag[i] == r_req_tag)) begin
                found      = 1'b1;
                match_line = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                have_empty = 1'b1;
                empty_line = IDX_W'(i);
            end
            if (r_rank[i] == RANK_OLDEST) begin
                victim_line = IDX_W'(i);
            end
        end
        if (found) begin
            n_line = match_line;
        end else if (have_empty) begin
            n_line = empty_line;
        end else begin
            n_line = victim_line;
        end
    end

    assign old_rank    = r_rank[r_line];
    assign n_hit_total = r_hit_total + falru_pkg::CNT_W'(r_hit);
    assign n_acc_total = r_acc_total + falru_pkg::CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_tag <= i_address[falru_pkg::ADDR_W-1:falru_pkg::TAG_SHIFT];
        end
        if (i_cmd.latch_cmp) begin
            r_hit  <= found;
            r_line <= n_line;
        end
        if (i_cmd.commit && !r_hit) begin
            r_tag[r_line] <= r_req_tag;
        end
        if (i_cmd.commit) begin
            r_out_hit  <= r_hit;
            r_out_hits <= n_hit_total;
            r_out_acc  <= n_acc_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_hit_total <= '0;
            r_acc_total <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LINES; i++) begin
                r_rank[i] <= IDX_W'(i);
            end
        end else begin
            if (i_cmd.commit) begin
                r_valid[r_line] <= 1'b1;
                r_hit_total     <= n_hit_total;
                r_acc_total     <= n_acc_total;
                // touched line to front, younger lines age by one
                for (int i = 0; i < LINES; i++) begin
                    if (IDX_W'(i) == r_line) begin
                        r_rank[i] <= '0;
                    end else if (r_rank[i] < old_rank) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free    = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid       = r_out_valid;
    assign o_hit             = r_out_hit;
    assign o_hits_so_far     = r_out_hits;
    assign o_accesses_so_far = r_out_acc;

endmodule

`default_nettype wire

FILE: rtl/core/falru_ctrl.sv
`default_nettype none

module falru_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    input  wire falru_pkg::t_dp_sts i_sts,
    output falru_pkg::t_dp_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.latch_cmp = 1'b1;
                n_state         = S_UPD;
            end
            S_UPD: begin
                // wait here while the previous result is still unread
                if (i_sts.out_free) begin
                    o_cmd.commit    = 1'b1;
                    o_cmd.req_ready = 1'b1;
                    if (i_req_valid) begin
                        o_cmd.load_req = 1'b1;
                        n_state        = S_CMP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fully_assoc_lru_cache_lookup.sv
// fully associative cache lookup, true lru, one-word lines
// a request is accepted, compared, then committed in update and held in the result register
// one request per compare/update pair, which share the line registers; update may
//   take the next request; stalls only while the result register is full
// reset: synchronous active-low i_rst_n empties all lines, ranks back to
//   line order, counters to zero; no clearing pass, ready right after reset
`default_nettype none

`include "fully_assoc_lru_cache_lookup_assert.svh"

module fully_assoc_lru_cache_lookup #(
    parameter int LINES = falru_pkg::LINES_DEFAULT
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    falru_req_if.sink     i_req,
    falru_rsp_if.source   o_rsp
);

    // command and status between sequencer and line datapath
    falru_pkg::t_dp_cmd cmd;
    falru_pkg::t_dp_sts sts;

    // sequencer: idle -> compare -> update; update may take the next request
    falru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // line tags, valid bits, recency ranks, counters and result register
    falru_datapath #(
        .LINES (LINES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_address         (i_req.address),
        .i_rsp_ready       (o_rsp.ready),
        .o_sts             (sts),
        .o_rsp_valid       (o_rsp.valid),
        .o_hit             (o_rsp.hit),
        .o_hits_so_far     (o_rsp.hits_so_far),
        .o_accesses_so_far (o_rsp.accesses_so_far)
    );

    // request taken only through the sequencer's ready
    assign i_req.ready = cmd.req_ready;

    // a loaded request goes to compare on the next cycle
    `FALRU_ASSERT_NXT(a_load_then_cmp, i_clk, i_rst_n, cmd.load_req, cmd.latch_cmp, "load without compare")
    // after compare the update fires exactly when the result slot is free
    `FALRU_ASSERT_NXT(a_cmp_then_commit, i_clk, i_rst_n, cmd.latch_cmp, cmd.commit == sts.out_free, "update not after compare")
    // a commit never overwrites an unread result
    `FALRU_ASSERT_IMP(a_commit_free, i_clk, i_rst_n, cmd.commit, sts.out_free, "result overwritten")
    // a new request is only loaded when ready is shown
    `FALRU_ASSERT_IMP(a_load_ready, i_clk, i_rst_n, cmd.load_req, cmd.req_ready && i_req.valid, "load without handshake")

endmodule

`default_nettype wire
